// ===== design/bblru_pkg.sv =====
// ============================================================================
// bblru_pkg
// Types and constants shared by the byte-budget LRU tag store and its checker.
// ============================================================================
package bblru_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = IDX_W + 1;
   localparam int KEY_W = 32;
   localparam int SIZE_W = 24;
   localparam int BYTES_W = 32;
   localparam int EVICT_W = 5;
   localparam logic [BYTES_W-1:0] BUDGET_RESET = 32'd1048576;

   typedef struct packed {
      logic [KEY_W-1:0]  key_id;
      logic [SIZE_W-1:0] object_bytes;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               stored;
      logic               flushed;
      logic [EVICT_W-1:0] evicted_count;
      logic [BYTES_W-1:0] bytes_in_use;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] bytes;
      logic [IDX_W-1:0]  rank;
   } row_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_HIT_PASS,
      ST_CHECK,
      ST_EVICT_PASS,
      ST_INSERT,
      ST_RESPOND
   } state_type;

endpackage

// ===== design/byte_budget_lru_tag_store.sv =====
// ============================================================================
// byte_budget_lru_tag_store
// LRU tag store whose capacity is a byte budget, with slot state in one RAM.
// ============================================================================
// A request word carries a key id and an object size; each request yields one
// response word with hit, stored, flushed, the eviction count and the bytes
// held afterwards. Both channels use valid/ready. The budget register is
// written through csr_we/csr_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this. Slot rows (key,
// size, age rank) live in a RAM with one write and one registered read
// port; valid bits, the live count and the byte total are flops. Every pass
// walks all SLOTS rows in read-modify-write order. A hit costs two passes
// (lookup, rank update), a miss one lookup pass plus one pass per evicted
// entry, then the insert state; an oversize miss flushes right after
// lookup. A new request is taken once the previous one has reached the
// response register; a stalled response holds that register and the block
// then waits before loading the next one.
// Reset clears all valid bits, the byte total and the response valid flag and
// restores the budget to 1 MiB; no clearing pass is needed.
// ============================================================================
module byte_budget_lru_tag_store
   import bblru_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_word,
   input  logic               csr_we,
   input  logic [BYTES_W-1:0] csr_wdata
);

   row_type row_mem [SLOTS];

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               chk_ff, chk_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   row_type            row_rd_ff;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   logic [BYTES_W-1:0] used_ff, used_in;
   logic [BYTES_W-1:0] budget_ff;
   req_type            req_ff, req_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]   found_rank_ff, found_rank_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [EVICT_W-1:0] evict_ff, evict_in;
   logic               stored_ff, stored_in;
   logic               flushed_ff, flushed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               mem_re;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   row_type            mem_wdata;
   logic               chk_v;
   logic               pass_end;
   logic               victim;
   logic               over_budget;
   logic               oversize;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign chk_v       = valid_ff[chk_idx_ff];
   assign pass_end    = chk_ff && (chk_idx_ff == IDX_W'(SLOTS - 1));
   assign victim      = chk_v && (row_rd_ff.rank == '0);
   assign over_budget = ({1'b0, used_ff} + {9'b0, req_ff.object_bytes}) > {1'b0, budget_ff};
   assign oversize    = {8'b0, req_ff.object_bytes} > budget_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         row_rd_ff <= row_mem[scan_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_ff       <= 1'b0;
         valid_ff     <= '0;
         live_ff      <= '0;
         used_ff      <= '0;
         budget_ff    <= BUDGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         valid_ff     <= valid_in;
         live_ff      <= live_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            budget_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      req_ff        <= req_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_rank_ff <= found_rank_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      evict_ff      <= evict_in;
      stored_ff     <= stored_in;
      flushed_ff    <= flushed_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      chk_in        = 1'b0;
      chk_idx_in    = scan_ff[IDX_W-1:0];
      valid_in      = valid_ff;
      live_in       = live_ff;
      used_in       = used_ff;
      req_in        = req_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_rank_in = found_rank_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      evict_in      = evict_ff;
      stored_in     = stored_ff;
      flushed_in    = flushed_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = chk_idx_ff;
      mem_wdata     = row_rd_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if ((state_ff == ST_LOOKUP) || (state_ff == ST_HIT_PASS) ||
          (state_ff == ST_EVICT_PASS)) begin
         if (scan_ff < CNT_W'(SLOTS)) begin
            mem_re  = 1'b1;
            chk_in  = 1'b1;
            scan_in = scan_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in     = req_word;
               scan_in    = '0;
               found_in   = 1'b0;
               free_in    = 1'b0;
               evict_in   = '0;
               stored_in  = 1'b0;
               flushed_in = 1'b0;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (chk_ff) begin
               if (chk_v && (row_rd_ff.key == req_ff.key_id) && !found_ff) begin
                  found_in      = 1'b1;
                  found_idx_in  = chk_idx_ff;
                  found_rank_in = row_rd_ff.rank;
               end
               if (!chk_v && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end
            if (pass_end) begin
               if (found_in) begin
                  scan_in  = '0;
                  state_in = ST_HIT_PASS;
               end else if (oversize) begin
                  flushed_in = 1'b1;
                  evict_in   = (live_ff > CNT_W'(31)) ? EVICT_W'(31) : EVICT_W'(live_ff);
                  valid_in   = '0;
                  used_in    = '0;
                  live_in    = '0;
                  state_in   = ST_RESPOND;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_HIT_PASS: begin
            if (chk_ff && chk_v) begin
               mem_we = 1'b1;
               if (chk_idx_ff == found_idx_ff) begin
                  mem_wdata.rank = IDX_W'(live_ff - 1'b1);
               end else if (row_rd_ff.rank > found_rank_ff) begin
                  mem_wdata.rank = row_rd_ff.rank - 1'b1;
               end
            end
            if (pass_end) begin
               state_in = ST_RESPOND;
            end
         end
         ST_CHECK: begin
            if ((live_ff != '0) && (over_budget || (live_ff == CNT_W'(SLOTS)))) begin
               scan_in  = '0;
               free_in  = 1'b0;
               state_in = ST_EVICT_PASS;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_EVICT_PASS: begin
            if (chk_ff) begin
               if (victim) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  used_in  = used_ff - {8'b0, row_rd_ff.bytes};
                  live_in  = live_ff - 1'b1;
                  if (evict_ff != EVICT_W'(31)) begin
                     evict_in = evict_ff + 1'b1;
                  end
               end else if (chk_v) begin
                  mem_we         = 1'b1;
                  mem_wdata.rank = row_rd_ff.rank - 1'b1;
               end
               if ((!chk_v || victim) && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end
            if (pass_end) begin
               state_in = ST_CHECK;
            end
         end
         ST_INSERT: begin
            mem_we                = 1'b1;
            mem_waddr             = free_idx_ff;
            mem_wdata.key         = req_ff.key_id;
            mem_wdata.bytes       = req_ff.object_bytes;
            mem_wdata.rank        = live_ff[IDX_W-1:0];
            valid_in[free_idx_ff] = 1'b1;
            used_in               = used_ff + {8'b0, req_ff.object_bytes};
            live_in               = live_ff + 1'b1;
            stored_in             = 1'b1;
            state_in              = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.hit           = found_ff;
               rsp_in.stored        = stored_ff;
               rsp_in.flushed       = flushed_ff;
               rsp_in.evicted_count = evict_ff;
               rsp_in.bytes_in_use  = used_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/bblru_checker.sv =====
// ============================================================================
// bblru_checker
// Port-level assertions for the byte-budget LRU tag store, bound to the top.
// ============================================================================
module bblru_checker
   import bblru_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_word
);

   // A response word that is not taken holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // The block works on one request at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A hit neither stores, flushes nor evicts.
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.hit |->
         !rsp_word.stored && !rsp_word.flushed && (rsp_word.evicted_count == '0))
      else $error("hit response reports miss activity");

   // A flush leaves the store empty and stores nothing.
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.flushed |->
         (rsp_word.bytes_in_use == '0) && !rsp_word.stored)
      else $error("flush left bytes in use");

endmodule

bind byte_budget_lru_tag_store bblru_checker u_bblru_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the byte-budget LRU tag store.
// ============================================================================
// Every request word accepted by the store is run through a local model of the
// slot table, and the predicted status word is queued. Each response word is
// compared field by field with the oldest queued status. Directed sequences
// cover zero-size objects, oversize flushes, slot-full eviction and a lowered
// budget. Random traffic then runs under several budgets and idling patterns.
// ============================================================================
module testbench;
   import bblru_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 400;
   localparam int POOL_SIZE = 24;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_word;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_word;
   logic               csr_we;
   logic [BYTES_W-1:0] csr_wdata;

   logic               slot_used [SLOTS];
   logic [KEY_W-1:0]   slot_tag [SLOTS];
   logic [SIZE_W-1:0]  slot_size [SLOTS];
   logic [IDX_W-1:0]   slot_rank [SLOTS];
   logic [BYTES_W-1:0] held_bytes;
   logic [BYTES_W-1:0] budget_bytes;

   rsp_type            due_outcomes [$];
   logic [KEY_W-1:0]   key_pool [POOL_SIZE];
   int                 error_count = 0;
   int                 quiet_cycles = 0;
   int                 idle_pct = 0;
   int                 stall_pct = 0;

   byte_budget_lru_tag_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic rsp_type cache_access(req_type word);
      rsp_type     outcome;
      int          found;
      int          live;
      int          evicted;
      int          victim;
      logic [IDX_W-1:0] old_rank;
      logic [BYTES_W:0] need;
      logic        placed;
      outcome = '0;
      found = -1;
      live = 0;
      evicted = 0;
      placed = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i]) begin
            live++;
         end
         if (slot_used[i] && slot_tag[i] == word.key_id && found < 0) begin
            found = i;
         end
      end
      if (found >= 0) begin
         outcome.hit = 1'b1;
         old_rank = slot_rank[found];
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_rank[i] > old_rank) begin
               slot_rank[i] = slot_rank[i] - 1'b1;
            end
         end
         slot_rank[found] = IDX_W'(live - 1);
      end else if ({8'd0, word.object_bytes} > budget_bytes) begin
         outcome.flushed = 1'b1;
         evicted = live;
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
         end
         held_bytes = '0;
      end else begin
         need = {1'b0, held_bytes} + {9'd0, word.object_bytes};
         while (live > 0 && (need > {1'b0, budget_bytes} || live >= SLOTS)) begin
            victim = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && slot_rank[i] == '0) begin
                  victim = i;
               end
            end
            slot_used[victim] = 1'b0;
            held_bytes = held_bytes - {8'd0, slot_size[victim]};
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i]) begin
                  slot_rank[i] = slot_rank[i] - 1'b1;
               end
            end
            live--;
            evicted++;
            need = {1'b0, held_bytes} + {9'd0, word.object_bytes};
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i] && !placed) begin
               placed = 1'b1;
               slot_used[i] = 1'b1;
               slot_tag[i] = word.key_id;
               slot_size[i] = word.object_bytes;
               slot_rank[i] = IDX_W'(live);
               held_bytes = held_bytes + {8'd0, word.object_bytes};
               outcome.stored = 1'b1;
            end
         end
      end
      outcome.evicted_count = (evicted > 31) ? EVICT_W'(31) : EVICT_W'(evicted);
      outcome.bytes_in_use = held_bytes;
      return outcome;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_outcomes.size() == 0) begin
            report_mismatch("unexpected response word", rsp_word.bytes_in_use, '0);
         end else begin
            want = due_outcomes.pop_front();
            if (rsp_word.hit !== want.hit) begin
               report_mismatch("hit", 32'(rsp_word.hit), 32'(want.hit));
            end
            if (rsp_word.stored !== want.stored) begin
               report_mismatch("stored", 32'(rsp_word.stored), 32'(want.stored));
            end
            if (rsp_word.flushed !== want.flushed) begin
               report_mismatch("flushed", 32'(rsp_word.flushed), 32'(want.flushed));
            end
            if (rsp_word.evicted_count !== want.evicted_count) begin
               report_mismatch("evicted_count", 32'(rsp_word.evicted_count),
                               32'(want.evicted_count));
            end
            if (rsp_word.bytes_in_use !== want.bytes_in_use) begin
               report_mismatch("bytes_in_use", rsp_word.bytes_in_use, want.bytes_in_use);
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(input logic [KEY_W-1:0] key, input logic [SIZE_W-1:0] bytes);
      req_type word;
      word.key_id = key;
      word.object_bytes = bytes;
      @(negedge clock);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < idle_pct) begin
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_word <= word;
      do begin
         @(posedge clock);
      end while (!req_ready);
      due_outcomes.push_back(cache_access(word));
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_budget(input logic [BYTES_W-1:0] value);
      settle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      budget_bytes = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(input logic [BYTES_W-1:0] budget, input int idle,
                             input int stall, input int count);
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] bytes;
      logic [BYTES_W-1:0] cap;
      int                pick;
      set_budget(budget);
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end
      cap = budget / 6;
      if (cap > 32'h00FF_FFFF) begin
         cap = 32'h00FF_FFFF;
      end
      for (int n = 0; n < count; n++) begin
         key = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
         pick = $urandom_range(99);
         if (pick < 10) begin
            bytes = '0;
         end else if (pick < 20) begin
            bytes = SIZE_W'($urandom);
         end else begin
            bytes = SIZE_W'($urandom_range(cap, 0));
         end
         send_request(key, bytes);
      end
   endtask

   task automatic test_directed_basics();
      idle_pct = 0;
      stall_pct = 0;
      send_request(32'h0000_0000, 24'd0);
      send_request(32'hFFFF_FFFF, 24'hFF_FFFF);
      send_request(32'hFFFF_FFFF, 24'h10_0000);
      send_request(32'hFFFF_FFFF, 24'd5);
      send_request(32'h0000_0000, 24'd1);
      for (int k = 1; k < SLOTS; k++) begin
         send_request(KEY_W'(k), 24'd0);
      end
      send_request(32'h0000_0001, 24'd7);
      send_request(32'h8000_0000, 24'd0);
      send_request(32'h7FFF_FFFF, 24'hFF_FFFF);
   endtask

   task automatic test_budget_shrink();
      set_budget(32'h0020_0000);
      for (int k = 0; k < 4; k++) begin
         send_request(32'hA5A5_0000 + KEY_W'(k), 24'h08_0000);
      end
      set_budget(BUDGET_RESET);
      send_request(32'h5A5A_5A5A, 24'h00_0010);
   endtask

   task automatic test_budget_extremes();
      run_random(32'h0000_0000, 37, 37, 60);
      run_random(32'hFFFF_FFFF, 61, 0, 90);
   endtask

   task automatic test_random_traffic();
      run_random(BUDGET_RESET, 0, 0, 95);
      run_random(32'd5000, 0, 61, 95);
      run_random(32'd50_000_000, 37, 37, 95);
      run_random(32'd300_000, 61, 0, 95);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      held_bytes = '0;
      budget_bytes = BUDGET_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_budget_shrink();
      test_budget_extremes();
      test_random_traffic();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && due_outcomes.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
